// ----- rtl/uesc2u8_pkg.sv -----
// uesc2u8_pkg: constants, types and the hex digit decoder shared by the
// Unicode escape to UTF-8 core. Depends on nothing.
package uesc2u8_pkg;

  localparam int HELD_DEPTH = 9;

  typedef logic [7:0] char_t;
  typedef logic [3:0] cnt_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_LOW_U  = 8'h75;
  localparam char_t CH_UP_U   = 8'h55;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_LOW_A  = 8'h61;
  localparam char_t CH_LOW_F  = 8'h66;
  localparam char_t CH_UP_A   = 8'h41;
  localparam char_t CH_UP_F   = 8'h46;

  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  // held count at which the incoming digit completes the escape
  localparam cnt_t HC_DONE_SHORT = 4'd5;
  localparam cnt_t HC_DONE_LONG  = 4'd9;

  localparam logic [31:0] CP_MAX_1B     = 32'h0000_007F;
  localparam logic [31:0] CP_MAX_2B     = 32'h0000_07FF;
  localparam logic [31:0] CP_MAX_3B     = 32'h0000_FFFF;
  localparam logic [31:0] CP_SURR_BELOW = 32'h0000_D7FF;
  localparam logic [31:0] CP_SURR_END   = 32'h0000_E000;
  localparam logic [31:0] CP_MAX        = 32'h0010_FFFF;

  localparam char_t LEAD_1B   = 8'h00;
  localparam char_t LEAD_2B   = 8'hC0;
  localparam char_t LEAD_3B   = 8'hE0;
  localparam char_t LEAD_4B   = 8'hF0;
  localparam char_t CONT_MARK = 8'h80;
  localparam char_t CONT_MASK = 8'h3F;

  localparam logic [2:0] NB_1 = 3'd1;
  localparam logic [2:0] NB_2 = 3'd2;
  localparam logic [2:0] NB_3 = 3'd3;
  localparam logic [2:0] NB_4 = 3'd4;

  function automatic hex_t hex_decode(input char_t c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.val = c[3:0];
    end else if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      h.val = c[3:0] + HEX_LETTER_OFS;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/unicode_escape_to_utf8_core.sv -----
// unicode_escape_to_utf8_core: streaming \uXXXX / \UXXXXXXXX decoder that
// emits UTF-8 or literal bytes through one byte sequencer and shifter.
// Depends on uesc2u8_pkg.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid in_ready in_char in_last      | in
//   result  | out_valid out_ready out_byte out_last  | out
//
// An item yields N bytes (0 to 10): after the accept cycle, the sequencer
// moves one byte per cycle into the output register while not stalled.
// in_ready is high only while the sequencer is idle.
// A stall on out_ready freezes the sequencer; the output register holds.
// rst_n is synchronous and active low; the held escape bytes have no reset.
module unicode_escape_to_utf8_core
  import uesc2u8_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  char_t in_char,
  input  logic  in_last,
  output logic  out_valid,
  input  logic  out_ready,
  output char_t out_byte,
  output logic  out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_A    = 2'd1;
  localparam logic [1:0] ST_B    = 2'd2;
  localparam logic [1:0] ST_C    = 2'd3;

  logic [1:0]  st_r, st_nxt;
  cnt_t        hc_r, hc_nxt;
  logic        lf_r, lf_nxt;
  logic [31:0] cp_r, cp_nxt;
  char_t       held_r [HELD_DEPTH];
  char_t       c_r, c_nxt;
  logic        last_r, last_nxt;
  cnt_t        a_cnt_r, a_cnt_nxt;
  logic [2:0]  b_cnt_r, b_cnt_nxt;
  logic        b_lit_r, b_lit_nxt;
  logic [2:0]  nb_r, nb_nxt;
  cnt_t        c_cnt_r, c_cnt_nxt;
  cnt_t        idx_r, idx_nxt;
  logic [20:0] enc_r, enc_nxt;
  logic        out_valid_r, out_valid_nxt;
  char_t       out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        wr_en;
  cnt_t        wr_idx;
  logic        rd_held;
  logic        accept;
  logic        load;
  hex_t        hx;
  logic [31:0] cpn;
  logic        cp_bad;
  logic [2:0]  nb_calc;
  logic [1:0]  pos;
  logic [4:0]  shamt;
  logic [20:0] shifted;
  char_t       lead;
  char_t       enc_byte;

  assign accept    = in_valid && in_ready;
  assign load      = !out_valid_r || out_ready;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  assign hx     = hex_decode(in_char);
  assign cpn    = {cp_r[27:0], hx.val};
  assign cp_bad = (cpn > CP_SURR_BELOW && cpn < CP_SURR_END) || cpn > CP_MAX;

  always_comb begin
    if (cpn <= CP_MAX_1B) nb_calc = NB_1;
    else if (cpn <= CP_MAX_2B) nb_calc = NB_2;
    else if (cpn <= CP_MAX_3B) nb_calc = NB_3;
    else nb_calc = NB_4;
  end

  // shared shifter: slice out the 6-bit group for the current UTF-8 byte
  assign pos     = 2'(b_cnt_r - 3'd1);
  assign shamt   = 5'({pos, 2'b00}) + 5'({pos, 1'b0});
  assign shifted = enc_r >> shamt;

  always_comb begin
    unique case (nb_r)
      NB_1:    lead = LEAD_1B;
      NB_2:    lead = LEAD_2B;
      NB_3:    lead = LEAD_3B;
      default: lead = LEAD_4B;
    endcase
  end

  assign enc_byte = (b_cnt_r == nb_r) ? (lead | shifted[7:0])
                                      : (CONT_MARK | (shifted[7:0] & CONT_MASK));

  always_comb begin
    st_nxt        = st_r;
    hc_nxt        = hc_r;
    lf_nxt        = lf_r;
    cp_nxt        = cp_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    a_cnt_nxt     = a_cnt_r;
    b_cnt_nxt     = b_cnt_r;
    b_lit_nxt     = b_lit_r;
    nb_nxt        = nb_r;
    c_cnt_nxt     = c_cnt_r;
    idx_nxt       = idx_r;
    enc_nxt       = enc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_idx        = '0;
    rd_held       = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
        end
        if (accept) begin
          c_nxt     = in_char;
          last_nxt  = in_last;
          a_cnt_nxt = '0;
          b_cnt_nxt = '0;
          b_lit_nxt = 1'b1;
          nb_nxt    = NB_1;
          c_cnt_nxt = '0;
          idx_nxt   = '0;
          if (hc_r == 4'd0 || (hc_r == 4'd1 && in_char != CH_LOW_U && in_char != CH_UP_U)
              || (hc_r >= 4'd2 && !hx.ok)) begin
            // emit any held bytes as literal text, then treat the byte as fresh text
            a_cnt_nxt = hc_r;
            hc_nxt    = '0;
            lf_nxt    = 1'b0;
            cp_nxt    = '0;
            if (in_char == CH_BSLASH) begin
              hc_nxt = 4'd1;
              wr_en  = 1'b1;
              wr_idx = '0;
            end else begin
              b_cnt_nxt = 3'd1;
            end
          end else if (hc_r == 4'd1) begin
            lf_nxt = (in_char == CH_UP_U);
            hc_nxt = 4'd2;
            wr_en  = 1'b1;
            wr_idx = hc_r;
          end else if (hc_r >= (lf_r ? HC_DONE_LONG : HC_DONE_SHORT)) begin
            hc_nxt = '0;
            lf_nxt = 1'b0;
            cp_nxt = '0;
            if (cp_bad) begin
              a_cnt_nxt = hc_r;
              b_cnt_nxt = 3'd1;
            end else begin
              b_lit_nxt = 1'b0;
              b_cnt_nxt = nb_calc;
              nb_nxt    = nb_calc;
              enc_nxt   = cpn[20:0];
            end
          end else begin
            cp_nxt = cpn;
            hc_nxt = hc_r + 4'd1;
            wr_en  = 1'b1;
            wr_idx = hc_r;
          end

          if (in_last) begin
            c_cnt_nxt = hc_nxt;
            hc_nxt    = '0;
            lf_nxt    = 1'b0;
            cp_nxt    = '0;
          end

          if (a_cnt_nxt != 4'd0) st_nxt = ST_A;
          else if (b_cnt_nxt != 3'd0) st_nxt = ST_B;
          else if (c_cnt_nxt != 4'd0) st_nxt = ST_C;
          else st_nxt = ST_IDLE;
        end
      end

      ST_A: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          rd_held       = 1'b1;
          out_last_nxt  = last_r && (idx_r == 4'(a_cnt_r - 4'd1))
                          && b_cnt_r == 3'd0 && c_cnt_r == 4'd0;
          if (idx_r == 4'(a_cnt_r - 4'd1)) begin
            idx_nxt = '0;
            if (b_cnt_r != 3'd0) st_nxt = ST_B;
            else if (c_cnt_r != 4'd0) st_nxt = ST_C;
            else st_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end

      ST_B: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = b_lit_r ? c_r : enc_byte;
          out_last_nxt  = last_r && b_cnt_r == 3'd1 && c_cnt_r == 4'd0;
          b_cnt_nxt     = b_cnt_r - 3'd1;
          if (b_cnt_r == 3'd1) begin
            idx_nxt = '0;
            st_nxt  = (c_cnt_r != 4'd0) ? ST_C : ST_IDLE;
          end
        end
      end

      ST_C: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          rd_held       = 1'b1;
          out_last_nxt  = last_r && (idx_r == 4'(c_cnt_r - 4'd1));
          if (idx_r == 4'(c_cnt_r - 4'd1)) begin
            idx_nxt = '0;
            st_nxt  = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      hc_r        <= '0;
      lf_r        <= 1'b0;
      cp_r        <= '0;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      c_cnt_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      hc_r        <= hc_nxt;
      lf_r        <= lf_nxt;
      cp_r        <= cp_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      c_cnt_r     <= c_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    last_r     <= last_nxt;
    b_lit_r    <= b_lit_nxt;
    nb_r       <= nb_nxt;
    enc_r      <= enc_nxt;
    out_last_r <= out_last_nxt;
    if (rd_held) begin
      out_byte_r <= held_r[idx_r];
    end else begin
      out_byte_r <= out_byte_nxt;
    end
    if (wr_en) begin
      held_r[wr_idx] <= in_char;
    end
  end

  a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= 4'(HELD_DEPTH))
    else $error("held count beyond held store depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> hc_r == 4'd0 && cp_r == 32'd0 && !lf_r)
    else $error("escape state not cleared at end of text");

  a_lf_held: assert property (@(posedge clk) disable iff (!rst_n)
    lf_r |-> hc_r >= 4'd2)
    else $error("long form set without a held 'U'");

  a_cp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r < 4'd2 |-> cp_r == 32'd0)
    else $error("code point gathered with no digits held");

  a_enc_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_B |-> b_cnt_r != 3'd0 && b_cnt_r <= nb_r)
    else $error("encoder byte count out of range");

endmodule

// ----- verif/tb_unicode_escape_to_utf8_core.sv -----
// tb_unicode_escape_to_utf8_core: self-checking bench for the escape to UTF-8 core.
// Runs a directed table, then random texts under several idle mixes, and checks
// every output item against table bytes or its decoder model. Depends on uesc2u8_pkg.
module tb_unicode_escape_to_utf8_core
  import uesc2u8_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIR_ROWS = 25;
  localparam int NO_TYPED = -1;

  localparam logic [31:0] ONE_BYTE_MAX   = 32'h0000_007F;
  localparam logic [31:0] TWO_BYTE_MAX   = 32'h0000_07FF;
  localparam logic [31:0] THREE_BYTE_MAX = 32'h0000_FFFF;
  localparam logic [31:0] SURR_FIRST     = 32'h0000_D800;
  localparam logic [31:0] SURR_LAST      = 32'h0000_DFFF;
  localparam logic [31:0] UNICODE_MAX    = 32'h0010_FFFF;

  typedef struct {
    char_t b;
    logic  l;
  } utf8_out_t;

  typedef struct packed {
    char_t       c;
    logic        l;
    int          nx;
    logic [31:0] xb;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  char_t in_char = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  char_t out_byte;
  logic  out_last;

  int          in_typed_n = NO_TYPED;
  logic [31:0] in_typed_xb = '0;
  int          snd_idle = 0;
  int          rcv_stall = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;

  utf8_out_t utf8_q[$];
  char_t     step_q[$];
  char_t     txt_q[$];
  dir_row_t  dir_tab[DIR_ROWS];

  char_t       esc_buf[HELD_DEPTH];
  int          esc_len = 0;
  bit          esc_long = 1'b0;
  logic [31:0] esc_cp = '0;

  unicode_escape_to_utf8_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char(in_char),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_stall);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int hex_val(char_t c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  task automatic add_step(char_t c);
    step_q.insert(step_q.size(), c);
  endtask

  task automatic add_txt(char_t c);
    txt_q.insert(txt_q.size(), c);
  endtask

  task automatic flush_escape();
    for (int i = 0; i < esc_len; i++) add_step(esc_buf[i]);
    esc_len = 0;
    esc_long = 1'b0;
    esc_cp = '0;
  endtask

  task automatic open_or_pass(char_t c);
    if (c == CH_BSLASH) begin
      esc_buf[0] = c;
      esc_len = 1;
      esc_long = 1'b0;
      esc_cp = '0;
    end else begin
      add_step(c);
    end
  endtask

  task automatic emit_utf8(logic [31:0] v);
    if (v <= ONE_BYTE_MAX) begin
      add_step(v[7:0]);
    end else if (v <= TWO_BYTE_MAX) begin
      add_step({3'b110, v[10:6]});
      add_step({2'b10, v[5:0]});
    end else if (v <= THREE_BYTE_MAX) begin
      add_step({4'b1110, v[15:12]});
      add_step({2'b10, v[11:6]});
      add_step({2'b10, v[5:0]});
    end else begin
      add_step({5'b11110, v[20:18]});
      add_step({2'b10, v[17:12]});
      add_step({2'b10, v[11:6]});
      add_step({2'b10, v[5:0]});
    end
  endtask

  task automatic decode_char(char_t c);
    int d;
    d = hex_val(c);
    if (esc_len == 0) begin
      open_or_pass(c);
    end else if (esc_len == 1) begin
      if (c == CH_LOW_U || c == CH_UP_U) begin
        esc_long = (c == CH_UP_U);
        esc_buf[1] = c;
        esc_len = 2;
      end else begin
        flush_escape();
        open_or_pass(c);
      end
    end else if (d < 0) begin
      flush_escape();
      open_or_pass(c);
    end else begin
      esc_cp = {esc_cp[27:0], d[3:0]};
      if (esc_len - 1 >= (esc_long ? 8 : 4)) begin
        if ((esc_cp >= SURR_FIRST && esc_cp <= SURR_LAST) || esc_cp > UNICODE_MAX) begin
          flush_escape();
          add_step(c);
        end else begin
          emit_utf8(esc_cp);
          esc_len = 0;
          esc_long = 1'b0;
          esc_cp = '0;
        end
      end else begin
        esc_buf[esc_len] = c;
        esc_len++;
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    utf8_out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (utf8_q.size() == 0) begin
          $display("%0t: unexpected out item: expected none, got byte %h last %b",
                   $time, out_byte, out_last);
          mismatches++;
        end else begin
          e = utf8_q.pop_front();
          if (out_byte !== e.b || out_last !== e.l) begin
            $display("%0t: out mismatch: expected byte %h last %b, got byte %h last %b",
                     $time, e.b, e.l, out_byte, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        step_q.delete();
        decode_char(in_char);
        if (in_last) flush_escape();
        if (in_typed_n != NO_TYPED) begin
          step_q.delete();
          for (int k = 0; k < in_typed_n; k++) add_step(in_typed_xb[31 - 8 * k -: 8]);
        end
        foreach (step_q[k]) begin
          utf8_q.insert(utf8_q.size(), '{step_q[k], in_last && k == step_q.size() - 1});
        end
      end
    end
  end

  task automatic send(char_t c, logic l, int nx, logic [31:0] xb);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    in_last <= l;
    in_typed_n <= nx;
    in_typed_xb <= xb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (utf8_q.size() != 0);
  endtask

  function automatic char_t hex_char(logic [3:0] d);
    if (d < 4'd10) return CH_ZERO + char_t'(d);
    return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + char_t'(d) - 8'd10;
  endfunction

  task automatic put_hex(logic [31:0] v, int n);
    for (int k = n - 1; k >= 0; k--) add_txt(hex_char(v[4 * k +: 4]));
  endtask

  function automatic logic [31:0] pick_cp(bit wide);
    logic [31:0] v;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 13))
        0: v = 32'h0;
        1: v = 32'h7F;
        2: v = 32'h80;
        3: v = 32'h7FF;
        4: v = 32'h800;
        5: v = 32'hD7FF;
        6: v = 32'hD800;
        7: v = 32'hDFFF;
        8: v = 32'hE000;
        9: v = 32'hFFFF;
        10: v = 32'h10000;
        11: v = 32'h10FFFF;
        12: v = 32'h110000;
        default: v = 32'hFFFF_FFFF;
      endcase
      return wide ? v : {16'h0, v[15:0]};
    end
    if (!wide) return $urandom_range(0, 16'hFFFF);
    return ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 32'h10FFFF);
  endfunction

  function automatic char_t breaker();
    return ($urandom_range(0, 3) == 0) ? CH_BSLASH : char_t'($urandom_range(0, 255));
  endfunction

  task automatic gen_text();
    int  pieces;
    int  r;
    bit  wide;
    txt_q.delete();
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(0, 99);
      wide = (r >= 55);
      if (r < 25) begin
        add_txt(char_t'($urandom_range(0, 255)));
      end else if (r < 80) begin
        add_txt(CH_BSLASH);
        add_txt(wide ? CH_UP_U : CH_LOW_U);
        put_hex(pick_cp(wide), wide ? 8 : 4);
      end else begin
        wide = $urandom_range(0, 1);
        add_txt(CH_BSLASH);
        if ($urandom_range(0, 2) == 0) begin
          add_txt(breaker());
        end else begin
          add_txt(wide ? CH_UP_U : CH_LOW_U);
          put_hex($urandom, $urandom_range(0, wide ? 7 : 3));
          if ($urandom_range(0, 3) != 0) add_txt(breaker());
        end
      end
    end
  endtask

  initial begin
    int sent;
    dir_tab = '{
      '{"A", 1'b0, 1, 32'h4100_0000},
      '{8'h00, 1'b0, 1, 32'h0000_0000},
      '{8'hFF, 1'b0, 1, 32'hFF00_0000},
      '{CH_BSLASH, 1'b0, 0, 32'h0},
      '{CH_LOW_U, 1'b0, 0, 32'h0},
      '{"d", 1'b0, 0, 32'h0},
      '{"8", 1'b0, 0, 32'h0},
      '{"0", 1'b0, 0, 32'h0},
      '{"0", 1'b0, NO_TYPED, 32'h0},
      '{CH_BSLASH, 1'b0, 0, 32'h0},
      '{CH_UP_U, 1'b0, 0, 32'h0},
      '{"0", 1'b0, 0, 32'h0},
      '{"0", 1'b0, 0, 32'h0},
      '{"1", 1'b0, 0, 32'h0},
      '{"0", 1'b0, 0, 32'h0},
      '{"F", 1'b0, 0, 32'h0},
      '{"f", 1'b0, 0, 32'h0},
      '{"F", 1'b0, 0, 32'h0},
      '{"f", 1'b0, 4, 32'hF48F_BFBF},
      '{CH_BSLASH, 1'b0, 0, 32'h0},
      '{CH_BSLASH, 1'b0, 1, 32'h5C00_0000},
      '{"q", 1'b0, NO_TYPED, 32'h0},
      '{CH_BSLASH, 1'b0, 0, 32'h0},
      '{CH_LOW_U, 1'b0, 0, 32'h0},
      '{"1", 1'b1, NO_TYPED, 32'h0}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send(dir_tab[i].c, dir_tab[i].l, dir_tab[i].nx, dir_tab[i].xb);
    end
    drain();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 77; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 77; end
        default: begin snd_idle = 17; rcv_stall = 17; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        gen_text();
        foreach (txt_q[k]) send(txt_q[k], k == txt_q.size() - 1, NO_TYPED, '0);
        sent += txt_q.size();
      end
      drain();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && utf8_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
